### rtl/core/rle_byte_encoder_assert.svh
// assertion macros for the run-length byte encoder
`ifndef RLE_BYTE_ENCODER_ASSERT_SVH
`define RLE_BYTE_ENCODER_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define RBE_ASSERT_NOW(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBE_ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rbe_pkg.sv
// shared types and constants of the run-length byte encoder
package rbe_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 4;

  // longest run header, a run of 128 equal bytes
  localparam logic [BYTE_W-1:0] RUN_MAX = 8'd127;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_CLASSIFY,
    OP_PAIR_HDR,
    OP_PAIR_VAL,
    OP_FLUSH_HDR,
    OP_FLUSH_DATA,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel_end;
    logic in_flush;
  } cmd_t;

  typedef struct packed {
    logic held_valid;
    logic eos;
    logic flush_first;
    logic pair_emit;
    logic flush_any;
    logic flush_last;
    logic can_push;
    logic fin_ok;
    logic pend_full;
    logic run_zero;
  } sts_t;

endpackage

### rtl/core/rbe_in_if.sv
// raw byte channel: valid, ready and one input byte with its end flag
interface rbe_in_if;
  logic                       valid;
  logic                       ready;
  logic [rbe_pkg::BYTE_W-1:0] data_byte;
  logic                       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

### rtl/core/rbe_out_if.sv
// encoded channel: valid, ready and one packed word of up to eight bytes
interface rbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [rbe_pkg::WORD_W-1:0]  packed_bytes;
  logic [rbe_pkg::COUNT_W-1:0] byte_count;
  logic                        last_of_step;
  logic                        stream_done;

  modport source (output valid, packed_bytes, byte_count, last_of_step, stream_done,
                  input ready);
  modport sink (input valid, packed_bytes, byte_count, last_of_step, stream_done,
                output ready);
endinterface

### rtl/core/rbe_datapath.sv
// encoder datapath: byte state, literal store, word packer and output register
module rbe_datapath #(
  parameter int LITERAL_DEPTH = 128,
  parameter int OUT_BYTES     = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rbe_pkg::cmd_t               cmd,
  output rbe_pkg::sts_t               sts,
  input  rbe_pkg::byte_t              in_byte,
  input  logic                        in_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rbe_pkg::WORD_W-1:0]  out_word,
  output logic [rbe_pkg::COUNT_W-1:0] out_count,
  output logic                        out_last,
  output logic                        out_done
);

  localparam int IW = $clog2(LITERAL_DEPTH);
  localparam int CW = $clog2(OUT_BYTES + 1);

  rbe_pkg::byte_t d_byte;
  logic           d_end;
  rbe_pkg::byte_t held_byte;
  logic           held_valid;
  rbe_pkg::byte_t prev_byte;
  logic           prev_valid;
  rbe_pkg::byte_t run_count;
  rbe_pkg::byte_t run_next;
  rbe_pkg::byte_t pair_hdr;
  rbe_pkg::byte_t pair_val;

  rbe_pkg::byte_t store [LITERAL_DEPTH];
  rbe_pkg::byte_t rd_data;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  rd_addr;

  logic [OUT_BYTES-1:0][rbe_pkg::BYTE_W-1:0] acc;
  logic [OUT_BYTES-1:0][rbe_pkg::BYTE_W-1:0] acc_new;
  logic [CW-1:0]                             acc_cnt;
  logic [rbe_pkg::WORD_W-1:0]                pend_word;
  logic [rbe_pkg::COUNT_W-1:0]               pend_cnt;
  logic                                      pend_full;

  rbe_pkg::byte_t cur;
  rbe_pkg::byte_t lit_n;
  rbe_pkg::byte_t push_byte;
  rbe_pkg::byte_t hdr;
  logic           eq;
  logic           len_neg;
  logic           len_zero;
  logic           len_pos;
  logic           store_full;
  logic           single;
  logic           push;
  logic           push_end;
  logic           complete;
  logic           flush_last;
  logic           out_free;
  logic           load_out;
  logic           finish;

  // classification of the current byte
  always_comb begin
    cur        = cmd.sel_end ? d_byte : held_byte;
    eq         = !cmd.sel_end && (held_byte == d_byte);
    len_neg    = run_count[rbe_pkg::BYTE_W-1];
    len_zero   = (run_count == '0);
    len_pos    = !len_neg && !len_zero;
    lit_n      = 8'(8'd0 - run_count);
    store_full = len_neg && (lit_n >= 8'(LITERAL_DEPTH));
    single     = !eq && len_zero && prev_valid && (prev_byte == cur);
    if (eq) begin
      hdr = rbe_pkg::RUN_MAX;
    end else if (len_pos) begin
      hdr = run_count;
    end else begin
      hdr = '0;
    end
    if (eq) begin
      run_next = (run_count == rbe_pkg::RUN_MAX) ? '0 : run_count + 8'd1;
    end else if (len_pos || single) begin
      run_next = '0;
    end else begin
      run_next = run_count - 8'd1;
    end
    flush_last = (8'(idx) == lit_n - 8'd1);
  end

  // byte into the packer
  always_comb begin
    push      = 1'b1;
    push_byte = '0;
    push_end  = 1'b0;
    case (cmd.op)
      rbe_pkg::OP_PAIR_HDR:   push_byte = pair_hdr;
      rbe_pkg::OP_PAIR_VAL: begin
        push_byte = pair_val;
        push_end  = 1'b1;
      end
      rbe_pkg::OP_FLUSH_HDR:  push_byte = run_count;
      rbe_pkg::OP_FLUSH_DATA: begin
        push_byte = rd_data;
        push_end  = flush_last;
      end
      default:                push = 1'b0;
    endcase
    for (int i = 0; i < OUT_BYTES; i++) begin
      if (acc_cnt == CW'(i)) begin
        acc_new[i] = push_byte;
      end else if (acc_cnt > CW'(i)) begin
        acc_new[i] = acc[i];
      end else begin
        acc_new[i] = '0;
      end
    end
    complete = push && (push_end || (acc_cnt == CW'(OUT_BYTES - 1)));
    finish   = (cmd.op == rbe_pkg::OP_FINISH);
    out_free = !out_valid || out_ready;
    load_out = pend_full && (complete || finish);
    if (!cmd.in_flush) begin
      rd_addr = '0;
    end else if (cmd.op == rbe_pkg::OP_FLUSH_DATA) begin
      rd_addr = idx + IW'(1);
    end else begin
      rd_addr = idx;
    end
  end

  always_comb begin
    sts.held_valid  = held_valid;
    sts.eos         = d_end;
    sts.flush_first = (eq && len_neg) || (!eq && store_full);
    sts.pair_emit   = (!eq && len_pos) || single || (eq && run_count == rbe_pkg::RUN_MAX);
    sts.flush_any   = len_neg;
    sts.flush_last  = flush_last;
    sts.can_push    = !pend_full || out_free;
    sts.fin_ok      = !pend_full || out_free;
    sts.pend_full   = pend_full;
    sts.run_zero    = len_zero;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      prev_valid <= 1'b0;
      run_count  <= '0;
      acc_cnt    <= '0;
      pend_full  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (cmd.op)
        rbe_pkg::OP_CLASSIFY: begin
          prev_valid <= 1'b1;
          run_count  <= run_next;
        end
        rbe_pkg::OP_FLUSH_DATA: begin
          if (flush_last) begin
            run_count <= '0;
          end
        end
        rbe_pkg::OP_FINISH: begin
          if (d_end) begin
            held_valid <= 1'b0;
            prev_valid <= 1'b0;
            run_count  <= '0;
          end else begin
            held_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      if (push) begin
        acc_cnt <= complete ? '0 : acc_cnt + CW'(1);
      end
      if (complete) begin
        pend_full <= 1'b1;
      end else if (finish) begin
        pend_full <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      rbe_pkg::OP_ACCEPT: begin
        d_byte <= in_byte;
        d_end  <= in_end;
      end
      rbe_pkg::OP_CLASSIFY: begin
        prev_byte <= cur;
        pair_hdr  <= hdr;
        pair_val  <= cur;
        if (!eq && !len_pos) begin
          store[lit_n[IW-1:0]] <= cur;
        end
      end
      rbe_pkg::OP_FINISH: held_byte <= d_byte;
      default: ;
    endcase
    rd_data <= store[rd_addr];
    idx     <= rd_addr;
    if (push) begin
      acc <= acc_new;
    end
    if (complete) begin
      pend_word <= rbe_pkg::WORD_W'(acc_new);
      pend_cnt  <= rbe_pkg::COUNT_W'(acc_cnt) + rbe_pkg::COUNT_W'(1);
    end
    if (load_out) begin
      out_word  <= pend_word;
      out_count <= pend_cnt;
      out_last  <= finish;
      out_done  <= finish && d_end;
    end
  end

endmodule

### rtl/core/rbe_ctrl.sv
// encoder sequencer: walks each item through classification and emission steps
module rbe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          raw_valid,
  input  rbe_pkg::sts_t sts,
  output rbe_pkg::cmd_t cmd,
  output logic          ready
);

  typedef enum logic [2:0] {S_IDLE, S_CLS, S_PHDR, S_PVAL, S_FHDR, S_FDATA, S_FIN} state_t;
  typedef enum logic [1:0] {PH_HELD, PH_LAST, PH_END} phase_t;

  state_t state;
  state_t state_next;
  state_t adv_state;
  phase_t phase;
  phase_t phase_next;
  phase_t adv_phase;

  // where to go once the current byte has been dealt with
  always_comb begin
    if (phase == PH_HELD) begin
      adv_state = sts.eos ? S_CLS : S_FIN;
      adv_phase = PH_LAST;
    end else begin
      adv_state = S_CLS;
      adv_phase = PH_END;
    end
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    cmd.op       = rbe_pkg::OP_IDLE;
    cmd.sel_end  = (phase != PH_HELD);
    cmd.in_flush = (state == S_FDATA);
    case (state)
      S_IDLE: begin
        if (raw_valid) begin
          cmd.op     = rbe_pkg::OP_ACCEPT;
          state_next = S_CLS;
          phase_next = PH_HELD;
        end
      end
      S_CLS: begin
        if (phase == PH_END) begin
          state_next = sts.flush_any ? S_FHDR : S_FIN;
        end else if (phase == PH_HELD && !sts.held_valid) begin
          state_next = adv_state;
          phase_next = adv_phase;
        end else if (sts.flush_first) begin
          state_next = S_FHDR;
        end else begin
          cmd.op = rbe_pkg::OP_CLASSIFY;
          if (sts.pair_emit) begin
            state_next = S_PHDR;
          end else begin
            state_next = adv_state;
            phase_next = adv_phase;
          end
        end
      end
      S_PHDR: begin
        if (sts.can_push) begin
          cmd.op     = rbe_pkg::OP_PAIR_HDR;
          state_next = S_PVAL;
        end
      end
      S_PVAL: begin
        if (sts.can_push) begin
          cmd.op     = rbe_pkg::OP_PAIR_VAL;
          state_next = adv_state;
          phase_next = adv_phase;
        end
      end
      S_FHDR: begin
        if (sts.can_push) begin
          cmd.op     = rbe_pkg::OP_FLUSH_HDR;
          state_next = S_FDATA;
        end
      end
      S_FDATA: begin
        if (sts.can_push) begin
          cmd.op = rbe_pkg::OP_FLUSH_DATA;
          if (sts.flush_last) begin
            state_next = S_CLS;
          end
        end
      end
      S_FIN: begin
        if (sts.fin_ok) begin
          cmd.op     = rbe_pkg::OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_HELD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign ready = (state == S_IDLE);

endmodule

### rtl/core/rle_byte_encoder.sv
// top level of the run-length byte encoder
// Run-length encoder for a byte stream with one byte of lookahead. Each
// byte is held until its successor (or the end flag) arrives. A run of 2 to
// 128 equal bytes comes out as header k-1 and the byte; differing bytes
// collect in a literal store of LITERAL_DEPTH entries and come out as
// header -n and the n bytes; a lone byte left after a full 128-byte run
// comes out as header 0 and the byte. Each emission is packed into items
// of up to OUT_BYTES bytes, first byte in bits 7:0, unused bytes zero, and
// one item never mixes two emissions. last_of_step marks the final item
// caused by an input byte, stream_done the final item of the stream; a
// byte that only waits for its successor gives no item. One input item is
// handled at a time by a sequencer: a byte that just extends a run or
// joins the literal store passes accept, classify and finish; each pair
// emitted adds a header and a value step; each literal flush of n bytes
// adds the classify slot that spots it, the header, then one store read
// per cycle through the single read port while the output can take
// bytes; end of stream adds its own bookkeeping. A full literal flush
// thus holds input off until its last byte is read. Packed items pass
// through a pending word and an output register, so the downstream side
// may stall at any time; the sequencer just waits. The literal store is
// not cleared: only entries written since the last flush are ever read.
`include "rle_byte_encoder_assert.svh"

module rle_byte_encoder #(
  parameter int LITERAL_DEPTH = 128,
  parameter int OUT_BYTES     = 8
) (
  input logic       clk,
  input logic       rst,
  rbe_in_if.sink    raw_stream,
  rbe_out_if.source code_stream
);

  // command and status between sequencer and datapath
  rbe_pkg::cmd_t cmd;
  rbe_pkg::sts_t sts;

  // sequencer: owns the handshake on the raw side
  rbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_stream.valid),
    .sts       (sts),
    .cmd       (cmd),
    .ready     (raw_stream.ready)
  );

  // datapath: byte state, literal store, packer and output register
  rbe_datapath #(
    .LITERAL_DEPTH (LITERAL_DEPTH),
    .OUT_BYTES     (OUT_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (raw_stream.data_byte),
    .in_end    (raw_stream.end_of_stream),
    .out_valid (code_stream.valid),
    .out_ready (code_stream.ready),
    .out_word  (code_stream.packed_bytes),
    .out_count (code_stream.byte_count),
    .out_last  (code_stream.last_of_step),
    .out_done  (code_stream.stream_done)
  );

  // nothing of the previous item may linger in the pending word when idle
  `RBE_ASSERT_NOW(a_idle_pend_empty, clk, rst, raw_stream.ready, !sts.pend_full, "pending word left at idle")

  // a fresh stream starts with no run or literals counted
  `RBE_ASSERT_NOW(a_fresh_run_zero, clk, rst, raw_stream.ready && !sts.held_valid, sts.run_zero, "run count not clear at stream start")

  // closing an item that ends the stream drops the held byte
  `RBE_ASSERT_NEXT(a_end_drops_held, clk, rst, cmd.op == rbe_pkg::OP_FINISH && sts.eos, !sts.held_valid, "held byte kept after end of stream")

endmodule

### test/rle_code_checker.sv
// predictor and comparator for the encoded items of the run-length byte encoder
`timescale 1ns / 100ps

module rle_code_checker #(
  parameter int LITERAL_DEPTH = 128,
  parameter int OUT_BYTES     = 8
) (
  input  logic clk,
  input  logic rst,
  rbe_in_if    raw_mon,
  rbe_out_if   code_mon,
  output int   fail_count,
  output int   pending,
  output int   bytes_seen,
  output int   codes_seen
);

  typedef struct {
    logic [rbe_pkg::WORD_W-1:0]  packed_bytes;
    logic [rbe_pkg::COUNT_W-1:0] byte_count;
    logic                        last_of_step;
    logic                        stream_done;
  } code_item_t;

  code_item_t queued_codes[$];
  code_item_t step_codes[$];

  // encoder state as the predictor sees it
  rbe_pkg::byte_t held       = '0;
  logic           held_ok    = 1'b0;
  rbe_pkg::byte_t prior      = '0;
  logic           prior_ok   = 1'b0;
  int             tally      = 0;  // >0 equal pairs in the run, <0 minus bytes stored
  rbe_pkg::byte_t literals [LITERAL_DEPTH];

  int mismatches = 0;
  int waiting    = 0;
  int in_items   = 0;
  int out_items  = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;
  assign bytes_seen = in_items;
  assign codes_seen = out_items;

  // cut one emission into items of up to OUT_BYTES bytes
  function automatic void pack_emission(input rbe_pkg::byte_t bytes[$]);
    code_item_t w;
    int take;
    int pos;
    pos = 0;
    while (pos < bytes.size()) begin
      take = bytes.size() - pos;
      if (take > OUT_BYTES) take = OUT_BYTES;
      w.packed_bytes = '0;
      for (int i = 0; i < take; i++) w.packed_bytes[8*i +: 8] = bytes[pos+i];
      w.byte_count   = rbe_pkg::COUNT_W'(take);
      w.last_of_step = 1'b0;
      w.stream_done  = 1'b0;
      step_codes.push_back(w);
      pos += take;
    end
  endfunction

  function automatic void pack_pair(input rbe_pkg::byte_t header, input rbe_pkg::byte_t value);
    rbe_pkg::byte_t bytes[$];
    bytes.push_back(header);
    bytes.push_back(value);
    pack_emission(bytes);
  endfunction

  function automatic void flush_literals();
    rbe_pkg::byte_t bytes[$];
    if (tally >= 0) return;
    bytes.push_back(rbe_pkg::byte_t'(tally));
    for (int i = 0; i < -tally; i++) bytes.push_back(literals[i]);
    pack_emission(bytes);
    tally = 0;
  endfunction

  // settle one byte once its successor (or the end of the stream) is known
  function automatic void classify(input rbe_pkg::byte_t cur, input logic nxt_ok,
                                   input rbe_pkg::byte_t nxt);
    int len;
    len = tally;
    if (!nxt_ok || cur != nxt) begin
      if (len > 0) begin
        pack_pair(rbe_pkg::byte_t'(len), cur);
        len = 0;
      end else begin
        if (-len >= LITERAL_DEPTH) begin
          flush_literals();
          len = 0;
        end
        literals[-len] = cur;
        len--;
      end
      // lone byte left behind a full-length run
      if (len == -1 && prior_ok && prior == cur) begin
        pack_pair('0, cur);
        len = 0;
      end
    end else begin
      if (len < 0) begin
        flush_literals();
        len = 0;
      end
      if (len >= 127) begin
        pack_pair(rbe_pkg::RUN_MAX, cur);
        len = 0;
      end else begin
        len++;
      end
    end
    tally    = len;
    prior    = cur;
    prior_ok = 1'b1;
  endfunction

  function automatic void predict_step(input rbe_pkg::byte_t value, input logic eos);
    int tail;
    step_codes.delete();
    if (held_ok) classify(held, 1'b1, value);
    if (eos) begin
      classify(value, 1'b0, '0);
      flush_literals();
      held     = '0;
      held_ok  = 1'b0;
      prior    = '0;
      prior_ok = 1'b0;
      tally    = 0;
    end else begin
      held    = value;
      held_ok = 1'b1;
    end
    tail = step_codes.size() - 1;
    if (tail >= 0) begin
      step_codes[tail].last_of_step = 1'b1;
      step_codes[tail].stream_done  = eos;
    end
    foreach (step_codes[i]) queued_codes.push_back(step_codes[i]);
  endfunction

  always @(posedge clk) begin : watch
    code_item_t want;
    if (rst) begin
      held     = '0;
      held_ok  = 1'b0;
      prior    = '0;
      prior_ok = 1'b0;
      tally    = 0;
      queued_codes.delete();
    end else begin
      if (raw_mon.valid && raw_mon.ready) begin
        predict_step(raw_mon.data_byte, raw_mon.end_of_stream);
        in_items++;
      end
      if (code_mon.valid && code_mon.ready) begin
        out_items++;
        if (queued_codes.size() == 0) begin
          $error("encoded item with nothing expected: packed_bytes %h byte_count %0d",
                 code_mon.packed_bytes, code_mon.byte_count);
          mismatches++;
        end else begin
          want = queued_codes.pop_front();
          if (code_mon.packed_bytes !== want.packed_bytes) begin
            $error("packed_bytes: expected %h, actual %h",
                   want.packed_bytes, code_mon.packed_bytes);
            mismatches++;
          end
          if (code_mon.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, actual %0d",
                   want.byte_count, code_mon.byte_count);
            mismatches++;
          end
          if (code_mon.last_of_step !== want.last_of_step) begin
            $error("last_of_step: expected %b, actual %b",
                   want.last_of_step, code_mon.last_of_step);
            mismatches++;
          end
          if (code_mon.stream_done !== want.stream_done) begin
            $error("stream_done: expected %b, actual %b",
                   want.stream_done, code_mon.stream_done);
            mismatches++;
          end
        end
      end
    end
    waiting = queued_codes.size();
  end

endmodule

### test/tb_top.sv
// top of the run-length byte encoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int LIT_DEPTH    = 128;
  localparam int WORD_BYTES   = 8;
  localparam int RANDOM_BYTES = 480;
  // margin for a full literal flush plus output stalls
  localparam int DRAIN_CYCLES = 300;
  // hard time limit, set several times above the slowest legal run
  localparam int LIMIT_NS     = 5_000_000;

  logic clk    = 1'b0;
  logic rst    = 1'b1;
  // when set, neither side idles: back-to-back items on both channels
  logic steady = 1'b0;

  int fails;
  int pending;
  int bytes_seen;
  int codes_seen;
  int streams_sent = 0;

  rbe_in_if  raw_if ();
  rbe_out_if code_if ();

  rle_byte_encoder #(
    .LITERAL_DEPTH (LIT_DEPTH),
    .OUT_BYTES     (WORD_BYTES)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .raw_stream  (raw_if),
    .code_stream (code_if)
  );

  rle_code_checker #(
    .LITERAL_DEPTH (LIT_DEPTH),
    .OUT_BYTES     (WORD_BYTES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .raw_mon    (raw_if),
    .code_mon   (code_if),
    .fail_count (fails),
    .pending    (pending),
    .bytes_seen (bytes_seen),
    .codes_seen (codes_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // one raw byte: optional idle gap, then hold it until the block takes it.
  // valid is left high after acceptance so a following byte with no gap
  // goes out back to back without a low-high glitch in one time step
  task automatic send_byte(input rbe_pkg::byte_t value, input logic eos);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      raw_if.valid <= 1'b0;
    end
    @(negedge clk);
    raw_if.valid         <= 1'b1;
    raw_if.data_byte     <= value;
    raw_if.end_of_stream <= eos;
    do @(posedge clk); while (!raw_if.ready);
  endtask

  // a stream always ends with the end flag on its final byte
  task automatic send_stream(input rbe_pkg::byte_t bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    streams_sent++;
  endtask

  // stop sending and hold off until every predicted item has come out
  task automatic wait_drained();
    @(negedge clk);
    raw_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // a run of equal bytes of random value
  function automatic void add_run(ref rbe_pkg::byte_t s[$], input int len);
    rbe_pkg::byte_t value;
    value = rbe_pkg::byte_t'($urandom);
    repeat (len) s.push_back(value);
  endfunction

  // bytes that each differ from the one before, the previous segment included
  function automatic void add_literals(ref rbe_pkg::byte_t s[$], input int len);
    rbe_pkg::byte_t value;
    value = (s.size() > 0) ? s[s.size()-1] : rbe_pkg::byte_t'($urandom);
    repeat (len) begin
      value = value + rbe_pkg::byte_t'($urandom_range(1, 255));
      s.push_back(value);
    end
  endfunction

  // mostly short segments, now and then one long enough to hit the limits
  function automatic int draw_len();
    if ($urandom_range(0, 99) < 12) return $urandom_range(120, 136);
    return $urandom_range(1, 8);
  endfunction

  // downstream side: random stall before each encoded item
  initial begin : drain_side
    int stall;
    code_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        code_if.ready <= 1'b0;
      end
      @(negedge clk);
      code_if.ready <= 1'b1;
      do @(posedge clk); while (!code_if.valid);
    end
  end

  initial begin : stimulus
    rbe_pkg::byte_t s[$];
    int             random_bytes;
    int             shape;
    int             nseg;

    raw_if.valid         = 1'b0;
    raw_if.data_byte     = '0;
    raw_if.end_of_stream = 1'b0;
    random_bytes         = 0;
    shape                = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single byte of zero as a whole stream
    s = {8'h00};
    send_stream(s);
    // two all-ones bytes: shortest run
    s = {8'hFF, 8'hFF};
    send_stream(s);
    // pure literals with alternating bit patterns
    s = {8'h5A, 8'hA5, 8'h5A};
    send_stream(s);
    // run starting while a literal is stored, then a trailing literal
    s = {8'h11, 8'h22, 8'h22, 8'h22, 8'h33};
    send_stream(s);
    // nine literals: header and bytes spill over into a second item
    s = {8'h80, 8'h7F, 8'h01, 8'hFE, 8'hC3, 8'h3C, 8'h96, 8'h69, 8'h00};
    send_stream(s);
    // two runs back to back
    s = {8'h44, 8'h44, 8'h55, 8'h55};
    send_stream(s);

    // sender holds off until all predicted items are out
    wait_drained();

    // random part: well-formed runs and literal blocks, with some noise
    while (random_bytes < RANDOM_BYTES) begin
      s.delete();
      steady = ($urandom_range(0, 3) == 0);
      case (shape)
        // full-length run plus one more equal byte, then a different one:
        // gives the longest run header and the lone-byte header
        0: begin
          add_run(s, 129);
          add_literals(s, 1);
        end
        // more literals than the store holds
        1: add_literals(s, 130);
        default: begin
          if ($urandom_range(0, 9) < 7) begin
            nseg = $urandom_range(1, 6);
            repeat (nseg) begin
              if ($urandom_range(0, 1) == 1) add_run(s, draw_len());
              else add_literals(s, draw_len());
            end
          end else begin
            // noise, either full range or a tiny alphabet that makes short runs
            nseg = $urandom_range(1, 24);
            if ($urandom_range(0, 1) == 1) begin
              repeat (nseg) s.push_back(rbe_pkg::byte_t'($urandom));
            end else begin
              repeat (nseg) s.push_back(rbe_pkg::byte_t'($urandom_range(0, 3)));
            end
          end
        end
      endcase
      shape++;
      if ($urandom_range(0, 7) == 0) wait_drained();
      send_stream(s);
      random_bytes += s.size();
    end

    // all stimulus out: wait for the tail, then a little longer for strays
    steady = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d streams: %0d raw bytes in, %0d encoded items checked",
             streams_sent, bytes_seen, codes_seen);
    $display("including full-length runs, a full literal store and stalls on both sides");
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rbe_pkg.sv
rtl/core/rbe_in_if.sv
rtl/core/rbe_out_if.sv
rtl/core/rbe_datapath.sv
rtl/core/rbe_ctrl.sv
rtl/core/rle_byte_encoder.sv
test/rle_code_checker.sv
test/tb_top.sv
